// File: design/skt_pkg.sv
// Shared types and codes for the sorted key table.
package skt_pkg;

  typedef enum logic [2:0] {
    FN_FIND   = 3'd0,
    FN_INSERT = 3'd1,
    FN_APPEND = 3'd2,
    FN_POP    = 3'd3,
    FN_READ   = 3'd4,
    FN_REMOVE = 3'd5,
    FN_CLEAR  = 3'd6
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_BADPOS = 2'd2,
    STAT_FULL   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_CMP  = 2'd1,
    CELL_INS  = 2'd2,
    CELL_DEL  = 2'd3
  } cell_op_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_CMP  = 3'd1,
    S_SRCH = 3'd2,
    S_EXEC = 3'd3,
    S_DONE = 3'd4
  } state_e;

  localparam int FUNC_W = 3;
  localparam int KEY_W  = 32;
  localparam int POS_W  = 9;
  localparam int STAT_W = 2;
  localparam int IN_W   = 48;
  localparam int OUT_W  = 56;

endpackage

// File: design/sorted_key_table.sv
// Sorted key table top level: sequencer, search unit and a row of key cells.
// Insert, append, pop, read, clear, the unused code, and find or remove on an empty table
// pass from acceptance through the execute and done states. Otherwise find and remove go
// through the compare and search states first, one search step per cycle, at most ceil(log2(count+1)) + 1 steps.
// One item is in work at a time; the next is accepted in the cycle after the result is
// registered, even while it waits on m_axis_tready. Reset empties.
module sorted_key_table
  import skt_pkg::*;
#(
  parameter int CAPACITY  = 256,
  parameter int KEY_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_W-1:0]   s_axis_tdata,   // func[2:0], key[34:3], position[43:35]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_W-1:0]  m_axis_tdata    // found[0], slot[9:1], value[41:10],
                                            // status[43:42], occupancy[52:44]
);

  localparam int KW = (KEY_WIDTH < KEY_W) ? KEY_WIDTH : KEY_W;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam int SW = CW + 1;

  state_e state_q, state_d;
  logic [CW-1:0] count_q;

  func_e            func_q;
  logic [KW-1:0]    key_q;
  logic [POS_W-1:0] pos_q;
  logic [CW-1:0]    lo_q, hp_q, idx_q;
  logic             hit_q;

  logic             res_found_q;
  logic [POS_W-1:0] res_slot_q;
  logic [KEY_W-1:0] res_value_q;
  status_e          res_status_q;

  logic             out_valid_q, out_found_q;
  logic [POS_W-1:0] out_slot_q, out_occ_q;
  logic [KEY_W-1:0] out_value_q;
  status_e          out_status_q;

  logic accept, out_free;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // cell row
  logic [KW-1:0]       ent [CAPACITY];
  logic [CAPACITY-1:0] gt_vec, lt_vec;
  cell_op_e            cell_op;
  logic [IW-1:0]       cell_idx;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KW-1:0] left_w, right_w;
    if (i == 0) begin : g_lo
      assign left_w = key_q;
    end else begin : g_lo
      assign left_w = ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_hi
      assign right_w = ent[i];
    end else begin : g_hi
      assign right_w = ent[i+1];
    end
    skt_cell #(.IDX(i), .IW(IW), .KW(KW)) u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op),
      .idx_i   (cell_idx),
      .key_i   (key_q),
      .left_i  (left_w),
      .right_i (right_w),
      .entry_o (ent[i]),
      .gt_o    (gt_vec[i]),
      .lt_o    (lt_vec[i])
    );
  end

  // search step; hp is the upper bound plus one, so it never goes below zero
  logic          srch_more, mid_gt, mid_lt;
  logic [SW-1:0] mid_sum;
  logic [IW-1:0] mid;
  assign srch_more = lo_q < hp_q;
  assign mid_sum   = SW'(lo_q) + SW'(hp_q) - SW'(1);
  assign mid       = mid_sum[IW:1];
  assign mid_gt    = gt_vec[mid];
  assign mid_lt    = lt_vec[mid];

  // single read port over the cells
  logic [IW-1:0] rd_addr;
  logic [KW-1:0] rd_val;
  always_comb begin
    rd_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_val = rd_val | (ent[i] & {KW{rd_addr == IW'(i)}});
    end
  end

  // operation outcome, used in the execute state
  logic [XW-1:0]    pos_x, count_x;
  logic             ex_found, ex_rdsel;
  logic [POS_W-1:0] ex_slot;
  status_e          ex_status;
  logic [CW-1:0]    ex_count;
  cell_op_e         ex_op;
  logic [IW-1:0]    ex_idx;
  logic [KEY_W-1:0] ex_value;

  assign pos_x   = XW'(pos_q);
  assign count_x = XW'(count_q);

  always_comb begin
    ex_found  = 1'b0;
    ex_slot   = '0;
    ex_status = STAT_OK;
    ex_count  = count_q;
    ex_op     = CELL_HOLD;
    ex_idx    = '0;
    rd_addr   = '0;
    ex_rdsel  = 1'b0;
    case (func_q)
      FN_FIND, FN_REMOVE: begin
        ex_found = hit_q;
        ex_slot  = POS_W'(idx_q) + POS_W'(1);
        if (!hit_q) begin
          ex_status = STAT_EMPTY;
        end else if (func_q == FN_REMOVE) begin
          ex_op    = CELL_DEL;
          ex_idx   = IW'(idx_q);
          ex_count = count_q - CW'(1);
        end
      end
      FN_INSERT: begin
        if (count_q >= CW'(CAPACITY)) begin
          ex_status = STAT_FULL;
        end else if (pos_x == '0 || pos_x > count_x + XW'(1)) begin
          ex_status = STAT_BADPOS;
        end else begin
          ex_op    = CELL_INS;
          ex_idx   = IW'(pos_x - XW'(1));
          ex_count = count_q + CW'(1);
          ex_slot  = pos_q;
        end
      end
      FN_APPEND: begin
        if (count_q >= CW'(CAPACITY)) begin
          ex_status = STAT_FULL;
        end else begin
          ex_op    = CELL_INS;
          ex_idx   = IW'(count_q);
          ex_count = count_q + CW'(1);
          ex_slot  = POS_W'(count_q) + POS_W'(1);
        end
      end
      FN_POP: begin
        if (count_q == '0) begin
          ex_status = STAT_EMPTY;
        end else begin
          ex_slot  = POS_W'(count_q);
          ex_count = count_q - CW'(1);
          rd_addr  = IW'(count_q - CW'(1));
          ex_rdsel = 1'b1;
        end
      end
      FN_READ: begin
        if (count_q == '0) begin
          ex_status = STAT_EMPTY;
        end else if (pos_x == '0 || pos_x > count_x) begin
          ex_status = STAT_BADPOS;
        end else begin
          rd_addr  = IW'(pos_x - XW'(1));
          ex_rdsel = 1'b1;
          ex_slot  = pos_q;
        end
      end
      FN_CLEAR: begin
        ex_count = '0;
      end
      default: begin
      end
    endcase
    ex_value = ex_rdsel ? KEY_W'(rd_val) : '0;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          if ((func_e'(s_axis_tdata[FUNC_W-1:0]) == FN_FIND ||
               func_e'(s_axis_tdata[FUNC_W-1:0]) == FN_REMOVE) && count_q != '0) begin
            state_d = S_CMP;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_CMP:  state_d = S_SRCH;
      S_SRCH: begin
        if (!srch_more || (!mid_gt && !mid_lt)) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = 1'b0;
    cell_op       = CELL_HOLD;
    cell_idx      = '0;
    case (state_q)
      S_IDLE: s_axis_tready = 1'b1;
      S_CMP:  cell_op = CELL_CMP;
      S_EXEC: begin
        cell_op  = ex_op;
        cell_idx = ex_idx;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_EXEC) begin
        count_q <= ex_count;
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          func_q <= func_e'(s_axis_tdata[FUNC_W-1:0]);
          key_q  <= KW'(s_axis_tdata[FUNC_W +: KEY_W]);
          pos_q  <= s_axis_tdata[FUNC_W+KEY_W +: POS_W];
          lo_q   <= '0;
          hp_q   <= count_q;
          idx_q  <= '0;
          hit_q  <= 1'b0;
        end
      end
      S_SRCH: begin
        if (srch_more) begin
          if (mid_gt) begin
            lo_q <= CW'(mid) + CW'(1);
          end else if (mid_lt) begin
            hp_q <= CW'(mid);
          end else begin
            idx_q <= CW'(mid);
            hit_q <= 1'b1;
          end
        end else begin
          idx_q <= lo_q;
        end
      end
      S_EXEC: begin
        res_found_q  <= ex_found;
        res_slot_q   <= ex_slot;
        res_value_q  <= ex_value;
        res_status_q <= ex_status;
      end
      S_DONE: begin
        if (out_free) begin
          out_found_q  <= res_found_q;
          out_slot_q   <= res_slot_q;
          out_value_q  <= res_value_q;
          out_status_q <= res_status_q;
          out_occ_q    <= POS_W'(count_q);
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_occ_q, out_status_q, out_value_q, out_slot_q, out_found_q};

endmodule

// File: design/skt_cell.sv
// One table cell: holds a key, shifts with its neighbors, compares against the search key.
module skt_cell
  import skt_pkg::*;
#(
  parameter int IDX = 0,
  parameter int IW  = 8,
  parameter int KW  = 32
) (
  input  logic           clk_i,
  input  cell_op_e       op_i,
  input  logic [IW-1:0]  idx_i,
  input  logic [KW-1:0]  key_i,
  input  logic [KW-1:0]  left_i,
  input  logic [KW-1:0]  right_i,
  output logic [KW-1:0]  entry_o,
  output logic           gt_o,
  output logic           lt_o
);

  localparam logic [IW-1:0] MyIdx = IW'(IDX);

  logic [KW-1:0] entry_q, entry_d;
  logic          gt_q, lt_q, gt_d, lt_d;

  always_comb begin
    entry_d = entry_q;
    gt_d    = gt_q;
    lt_d    = lt_q;
    case (op_i)
      CELL_CMP: begin
        gt_d = key_i > entry_q;
        lt_d = key_i < entry_q;
      end
      CELL_INS: begin
        // open a hole at idx: cells above take from below
        if (MyIdx == idx_i) begin
          entry_d = key_i;
        end else if (MyIdx > idx_i) begin
          entry_d = left_i;
        end
      end
      CELL_DEL: begin
        if (MyIdx >= idx_i) begin
          entry_d = right_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    gt_q    <= gt_d;
    lt_q    <= lt_d;
  end

  assign entry_o = entry_q;
  assign gt_o    = gt_q;
  assign lt_o    = lt_q;

endmodule

// File: design/skt_checker.sv
// Port-level assertions for the sorted key table, bound to the top level.
module skt_checker
  import skt_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  logic             o_found;
  logic [STAT_W-1:0] o_status;
  logic [POS_W-1:0] o_occ;
  assign o_found  = m_axis_tdata[0];
  assign o_status = m_axis_tdata[43:42];
  assign o_occ    = m_axis_tdata[52:44];

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one item in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after an accepted item");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && o_found |-> o_status == STAT_OK)
    else $error("found flag with error status");

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && o_status == STAT_FULL |-> o_occ == POS_W'(CAPACITY))
    else $error("full status below capacity");

endmodule

bind sorted_key_table skt_checker #(.CAPACITY(CAPACITY)) u_skt_checker (.*);
